@@ hw/rtl/ihsp_pkg.sv @@
// Package for the image header size parser: window sizing, format codes,
// the queue entry passed from front to back, and marker classification.
// No dependencies.
package ihsp_pkg;

   localparam int HEADER_WINDOW_BYTES = 1024;
   localparam int POS_W               = $clog2(HEADER_WINDOW_BYTES + 1);
   localparam int SCAN_W              = $clog2(HEADER_WINDOW_BYTES + 65538);
   localparam int PNG_MIN_BYTES       = 24;
   localparam int QUEUE_DEPTH         = 4;
   localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W              = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PNG_FIRST_BYTE = 8'h89;
   localparam logic [7:0] MARKER_PREFIX  = 8'hFF;
   localparam logic [7:0] JPEG_SOI       = 8'hD8;
   localparam logic [7:0] MARKER_TEM     = 8'h01;
   localparam logic [7:0] MARKER_RST0    = 8'hD0;
   localparam logic [7:0] MARKER_EOI     = 8'hD9;
   localparam logic [7:0] MARKER_SOF0    = 8'hC0;
   localparam logic [7:0] MARKER_SOF15   = 8'hCF;
   localparam logic [7:0] MARKER_DHT     = 8'hC4;
   localparam logic [7:0] MARKER_JPG     = 8'hC8;
   localparam logic [7:0] MARKER_DAC     = 8'hCC;

   localparam logic [7:0] PNG_MAGIC [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                            8'h0D, 8'h0A, 8'h1A, 8'h0A};
   localparam logic [7:0] IHDR_TAG  [4] = '{8'h49, 8'h48, 8'h44, 8'h52};

   typedef enum logic [1:0] {
      FMT_UNKNOWN = 2'd0,
      FMT_PNG     = 2'd1,
      FMT_JPEG    = 2'd2,
      FMT_OTHER   = 2'd3
   } fmt_type;

   typedef struct packed {
      logic [7:0]       data;
      logic             last;
      logic [POS_W-1:0] pos;
      logic             in_window;
      logic             png_len_ok;
      logic             standalone;
      logic             sof;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qhead_type;

   function automatic logic is_standalone(input logic [7:0] m);
      return (m == MARKER_PREFIX) || (m == MARKER_TEM) ||
             ((m >= MARKER_RST0) && (m <= MARKER_EOI));
   endfunction

   function automatic logic is_sof(input logic [7:0] m);
      return (m >= MARKER_SOF0) && (m <= MARKER_SOF15) &&
             (m != MARKER_DHT) && (m != MARKER_JPG) && (m != MARKER_DAC);
   endfunction

endpackage

@@ hw/rtl/ihsp_front.sv @@
// Front end: counts byte positions inside the header window and tags each
// accepted byte with position and marker class for the back end.
// Depends on ihsp_pkg.
module ihsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_ok,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output ihsp_pkg::entry_type entry
);

   logic [ihsp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       in_window;

   assign in_window = pos_ff != ihsp_pkg::POS_W'(ihsp_pkg::HEADER_WINDOW_BYTES);

   always_comb begin
      pos_in = pos_ff;
      if (push_ok) begin
         if (last_byte) begin
            pos_in = '0;
         end else if (in_window) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_comb begin
      entry.data       = data_byte;
      entry.last       = last_byte;
      entry.pos        = pos_ff;
      entry.in_window  = in_window;
      entry.png_len_ok = !in_window ||
                         (pos_ff >= ihsp_pkg::POS_W'(ihsp_pkg::PNG_MIN_BYTES - 1));
      entry.standalone = ihsp_pkg::is_standalone(data_byte);
      entry.sof        = ihsp_pkg::is_sof(data_byte);
   end

endmodule

@@ hw/rtl/ihsp_queue.sv @@
// Short request queue decoupling the front end from the back end.
// Depends on ihsp_pkg.
module ihsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ihsp_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output ihsp_pkg::qhead_type head
);

   ihsp_pkg::entry_type         slot_ff [ihsp_pkg::QUEUE_DEPTH];
   logic [ihsp_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ihsp_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ihsp_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign full    = count_ff == ihsp_pkg::QCNT_W'(ihsp_pkg::QUEUE_DEPTH);
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = count_ff != '0;
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ihsp_pkg::QCNT_W'(ihsp_pkg::QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

@@ hw/rtl/ihsp_back.sv @@
// Back end: PNG signature check, JPEG marker walk and the result register.
// Depends on ihsp_pkg.
module ihsp_back (
   input  logic                clock,
   input  logic                reset,
   input  ihsp_pkg::qhead_type head,
   output logic                pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [31:0]         rsp_image_width,
   output logic [31:0]         rsp_image_height,
   output logic                rsp_size_found
);

   localparam int SCAN_W = ihsp_pkg::SCAN_W;

   ihsp_pkg::fmt_type   fmt_ff, fmt_in;
   logic                sig_ff, sig_in;
   logic [SCAN_W-1:0]   next_ff, next_in;
   logic [7:0]          len_hi_ff, len_hi_in;
   logic [31:0]         width_ff, width_in;
   logic [31:0]         height_ff, height_in;
   logic                sof_ff, sof_in;
   logic                stop_ff, stop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_width_ff, rsp_width_in;
   logic [31:0]         rsp_height_ff, rsp_height_in;
   logic                rsp_found_ff, rsp_found_in;

   ihsp_pkg::entry_type e;
   ihsp_pkg::fmt_type   fmt_n;
   logic                sig_n, sof_n, stop_n;
   logic [SCAN_W-1:0]   next_n;
   logic [7:0]          len_hi_n;
   logic [31:0]         width_n, height_n;
   logic [SCAN_W-1:0]   pos_ext, diff;
   logic                walk_act, found_raw, found;
   logic [15:0]         seg_len;
   logic [31:0]         res_w, res_h;

   assign e         = head.entry;
   assign pop       = head.valid && (!e.last || !rsp_valid_ff || rsp_pop);
   assign rsp_empty = !rsp_valid_ff;
   assign pos_ext   = SCAN_W'(e.pos);
   assign diff      = pos_ext - next_ff;
   assign seg_len   = {len_hi_ff, e.data};
   assign walk_act  = !stop_ff && (pos_ext >= next_ff) && (diff <= SCAN_W'(9));

   always_comb begin
      fmt_n    = fmt_ff;
      sig_n    = sig_ff;
      next_n   = next_ff;
      len_hi_n = len_hi_ff;
      width_n  = width_ff;
      height_n = height_ff;
      sof_n    = sof_ff;
      stop_n   = stop_ff;
      if (e.in_window) begin
         if (e.pos == '0) begin
            if (e.data == ihsp_pkg::PNG_FIRST_BYTE) begin
               fmt_n = ihsp_pkg::FMT_PNG;
            end else if (e.data == ihsp_pkg::MARKER_PREFIX) begin
               fmt_n = ihsp_pkg::FMT_JPEG;
            end else begin
               fmt_n = ihsp_pkg::FMT_OTHER;
            end
         end else if (fmt_ff == ihsp_pkg::FMT_PNG) begin
            if (e.pos < ihsp_pkg::POS_W'(8)) begin
               if (e.data != ihsp_pkg::PNG_MAGIC[e.pos[2:0]]) begin
                  sig_n = 1'b0;
               end
            end else if (e.pos >= ihsp_pkg::POS_W'(12) && e.pos < ihsp_pkg::POS_W'(16)) begin
               if (e.data != ihsp_pkg::IHDR_TAG[e.pos[1:0]]) begin
                  sig_n = 1'b0;
               end
            end else if (e.pos >= ihsp_pkg::POS_W'(16) && e.pos < ihsp_pkg::POS_W'(20)) begin
               width_n = {width_ff[23:0], e.data};
            end else if (e.pos >= ihsp_pkg::POS_W'(20) && e.pos < ihsp_pkg::POS_W'(24)) begin
               height_n = {height_ff[23:0], e.data};
            end
         end else if (fmt_ff == ihsp_pkg::FMT_JPEG) begin
            if (e.pos == ihsp_pkg::POS_W'(1)) begin
               if (e.data != ihsp_pkg::JPEG_SOI) begin
                  fmt_n = ihsp_pkg::FMT_OTHER;
               end
            end else if (walk_act) begin
               case (diff[3:0])
                  4'd0: begin
                     if (e.data != ihsp_pkg::MARKER_PREFIX) begin
                        next_n = pos_ext + 1'b1;
                     end
                  end
                  4'd1: begin
                     if (e.standalone) begin
                        next_n = next_ff + SCAN_W'(2);
                     end else if (e.sof) begin
                        sof_n = 1'b1;
                     end
                  end
                  4'd2: begin
                     if (!sof_ff) begin
                        len_hi_n = e.data;
                     end
                  end
                  4'd3: begin
                     if (!sof_ff) begin
                        if (seg_len < 16'd2) begin
                           stop_n = 1'b1;
                        end else begin
                           next_n = next_ff + SCAN_W'(seg_len) + SCAN_W'(2);
                        end
                     end
                  end
                  4'd5: begin
                     if (sof_ff) begin
                        height_n = {16'h0, e.data, 8'h0};
                     end
                  end
                  4'd6: begin
                     if (sof_ff) begin
                        height_n = height_ff | {24'h0, e.data};
                     end
                  end
                  4'd7: begin
                     if (sof_ff) begin
                        width_n = {16'h0, e.data, 8'h0};
                     end
                  end
                  4'd8: begin
                     if (sof_ff) begin
                        width_n = width_ff | {24'h0, e.data};
                     end
                  end
                  4'd9: begin
                     if (sof_ff) begin
                        sof_n  = 1'b0;
                        stop_n = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      found_raw = ((fmt_n == ihsp_pkg::FMT_PNG) && sig_n && e.png_len_ok) ||
                  ((fmt_n == ihsp_pkg::FMT_JPEG) && stop_n && !sof_n);
      found     = found_raw && (width_n != '0) && (height_n != '0);
      res_w     = found ? width_n : '0;
      res_h     = found ? height_n : '0;
   end

   always_comb begin
      fmt_in    = fmt_ff;
      sig_in    = sig_ff;
      next_in   = next_ff;
      len_hi_in = len_hi_ff;
      width_in  = width_ff;
      height_in = height_ff;
      sof_in    = sof_ff;
      stop_in   = stop_ff;
      if (pop) begin
         if (e.last) begin
            fmt_in    = ihsp_pkg::FMT_UNKNOWN;
            sig_in    = 1'b1;
            next_in   = SCAN_W'(2);
            len_hi_in = '0;
            width_in  = '0;
            height_in = '0;
            sof_in    = 1'b0;
            stop_in   = 1'b0;
         end else begin
            fmt_in    = fmt_n;
            sig_in    = sig_n;
            next_in   = next_n;
            len_hi_in = len_hi_n;
            width_in  = width_n;
            height_in = height_n;
            sof_in    = sof_n;
            stop_in   = stop_n;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_pop ? 1'b0 : rsp_valid_ff;
      rsp_width_in  = rsp_width_ff;
      rsp_height_in = rsp_height_ff;
      rsp_found_in  = rsp_found_ff;
      if (pop && e.last) begin
         rsp_valid_in  = 1'b1;
         rsp_width_in  = res_w;
         rsp_height_in = res_h;
         rsp_found_in  = found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= ihsp_pkg::FMT_UNKNOWN;
         sig_ff       <= 1'b1;
         next_ff      <= SCAN_W'(2);
         len_hi_ff    <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         sof_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         sig_ff       <= sig_in;
         next_ff      <= next_in;
         len_hi_ff    <= len_hi_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         sof_ff       <= sof_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_width_ff  <= rsp_width_in;
      rsp_height_ff <= rsp_height_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_image_width  = rsp_width_ff;
   assign rsp_image_height = rsp_height_ff;
   assign rsp_size_found   = rsp_found_ff;

   a_sof_in_walk: assert property (@(posedge clock) disable iff (reset)
      sof_ff |-> (fmt_ff == ihsp_pkg::FMT_JPEG) && !stop_ff)
      else $error("SOF pending outside an active JPEG walk");

   a_stop_jpeg: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> (fmt_ff == ihsp_pkg::FMT_JPEG))
      else $error("walk stopped outside JPEG");

   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_width_ff != '0) && (rsp_height_ff != '0))
      else $error("size reported found with a zero dimension");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_pop) |-> !(pop && e.last))
      else $error("result overwritten before it was taken");

endmodule

@@ hw/rtl/image_header_size_parser_top.sv @@
// Top level of the image header size parser.
// Instantiates ihsp_front, ihsp_queue and ihsp_back; depends on ihsp_pkg.
//
// One file byte enters per cycle through the push/full queue interface while
// the queue is not full; the byte flagged last produces exactly one result
// (width, height, found flag) on the pop/empty interface. A four-entry request
// queue separates the byte tagging front end from the parse back end, and the
// back end retires one byte per cycle, so sustained throughput is one byte per
// clock whenever results are popped as they appear. Only the first 1024 bytes
// of each file are parsed.
module image_header_size_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_image_width,
   output logic [31:0] rsp_image_height,
   output logic        rsp_size_found
);

   ihsp_pkg::entry_type entry;
   ihsp_pkg::qhead_type head;
   logic                push_ok;
   logic                back_pop;

   assign push_ok = req_push && !req_full;

   ihsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push_ok   (push_ok),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .entry     (entry)
   );

   ihsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .push_entry (entry),
      .full       (req_full),
      .pop        (back_pop),
      .head       (head)
   );

   ihsp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .pop              (back_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_size_found   (rsp_size_found)
   );

endmodule

@@ dv/tb_image_header_size_parser_top.sv @@
// Testbench for image_header_size_parser_top: streams PNG, JPEG and noise
// headers byte by byte and checks each size result against a built-in parser.
// Depends on ihsp_pkg and the RTL under hw/rtl.
module tb_image_header_size_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_PERIOD  = 20;
   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [31:0] width;
      logic [31:0] height;
      logic        found;
   } image_size_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_image_width;
   logic [31:0] rsp_image_height;
   logic        rsp_size_found;

   int unsigned errors = 0;
   bit          send_gaps_on = 1'b1;
   bit          pop_gaps_on = 1'b1;
   int unsigned pop_hold_request = 0;

   image_size_type expected_sizes[$];
   logic [7:0]     file_bytes[$];

   // parser state
   int unsigned       hdr_pos;
   ihsp_pkg::fmt_type hdr_fmt;
   logic              sig_ok;
   int unsigned       scan_pos;
   logic [7:0]        len_hi;
   logic [31:0]       width_acc;
   logic [31:0]       height_acc;
   logic              sof_wait;
   logic              walk_done;

   image_header_size_parser_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_size_found   (rsp_size_found)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic marker_has_no_length(input logic [7:0] m);
      return (m == ihsp_pkg::MARKER_PREFIX) || (m == ihsp_pkg::MARKER_TEM) ||
             ((m >= ihsp_pkg::MARKER_RST0) && (m <= ihsp_pkg::MARKER_EOI));
   endfunction

   function automatic logic marker_starts_frame(input logic [7:0] m);
      return (m >= ihsp_pkg::MARKER_SOF0) && (m <= ihsp_pkg::MARKER_SOF15) &&
             (m != ihsp_pkg::MARKER_DHT) && (m != ihsp_pkg::MARKER_JPG) &&
             (m != ihsp_pkg::MARKER_DAC);
   endfunction

   function automatic void clear_parse_state();
      hdr_pos    = 0;
      hdr_fmt    = ihsp_pkg::FMT_UNKNOWN;
      sig_ok     = 1'b1;
      scan_pos   = 2;
      len_hi     = 8'h00;
      width_acc  = 32'd0;
      height_acc = 32'd0;
      sof_wait   = 1'b0;
      walk_done  = 1'b0;
   endfunction

   function automatic void step_jpeg_walk(input int unsigned p, input logic [7:0] b);
      int unsigned off;
      logic [15:0] seg_len;
      if (walk_done || p < scan_pos) return;
      off = p - scan_pos;
      if (off > 9) return;
      case (off)
         0: begin
            if (b != ihsp_pkg::MARKER_PREFIX) scan_pos = p + 1;
         end
         1: begin
            if (marker_has_no_length(b)) scan_pos = scan_pos + 2;
            else if (marker_starts_frame(b)) sof_wait = 1'b1;
         end
         2: begin
            if (!sof_wait) len_hi = b;
         end
         3: begin
            if (!sof_wait) begin
               seg_len = {len_hi, b};
               if (seg_len < 16'd2) walk_done = 1'b1;
               else scan_pos = scan_pos + 2 + seg_len;
            end
         end
         5: if (sof_wait) height_acc = {16'd0, b, 8'd0};
         6: if (sof_wait) height_acc = height_acc | {24'd0, b};
         7: if (sof_wait) width_acc = {16'd0, b, 8'd0};
         8: if (sof_wait) width_acc = width_acc | {24'd0, b};
         9: begin
            if (sof_wait) begin
               sof_wait  = 1'b0;
               walk_done = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic last);
      int unsigned    p;
      logic           ok;
      image_size_type size;
      if (hdr_pos < ihsp_pkg::HEADER_WINDOW_BYTES) begin
         p = hdr_pos;
         hdr_pos = p + 1;
         if (p == 0) begin
            if (b == ihsp_pkg::PNG_FIRST_BYTE) hdr_fmt = ihsp_pkg::FMT_PNG;
            else if (b == ihsp_pkg::MARKER_PREFIX) hdr_fmt = ihsp_pkg::FMT_JPEG;
            else hdr_fmt = ihsp_pkg::FMT_OTHER;
         end else if (hdr_fmt == ihsp_pkg::FMT_PNG) begin
            if (p < 8 && b != ihsp_pkg::PNG_MAGIC[p]) sig_ok = 1'b0;
            else if (p >= 12 && p < 16 && b != ihsp_pkg::IHDR_TAG[p - 12]) sig_ok = 1'b0;
            else if (p >= 16 && p < 20) width_acc = {width_acc[23:0], b};
            else if (p >= 20 && p < 24) height_acc = {height_acc[23:0], b};
         end else if (hdr_fmt == ihsp_pkg::FMT_JPEG) begin
            if (p == 1) begin
               if (b != ihsp_pkg::JPEG_SOI) hdr_fmt = ihsp_pkg::FMT_OTHER;
            end else begin
               step_jpeg_walk(p, b);
            end
         end
      end
      if (last) begin
         ok = (hdr_fmt == ihsp_pkg::FMT_PNG && sig_ok &&
               hdr_pos >= ihsp_pkg::PNG_MIN_BYTES) ||
              (hdr_fmt == ihsp_pkg::FMT_JPEG && walk_done && !sof_wait);
         size.width  = ok ? width_acc : 32'd0;
         size.height = ok ? height_acc : 32'd0;
         size.found  = ok;
         if (size.width == 32'd0 || size.height == 32'd0) size = '0;
         expected_sizes.push_back(size);
         clear_parse_state();
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last);
      while (send_gaps_on && $urandom_range(99) < 13) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      file_bytes.delete();
   endtask

   task automatic add_png(input logic [31:0] w, input logic [31:0] h);
      for (int i = 0; i < 8; i++) file_bytes.push_back(ihsp_pkg::PNG_MAGIC[i]);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h0D);
      for (int i = 0; i < 4; i++) file_bytes.push_back(ihsp_pkg::IHDR_TAG[i]);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(h[8*i +: 8]);
   endtask

   task automatic add_segment(input logic [7:0] marker, input int unsigned len);
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(marker);
      file_bytes.push_back(len[15:8]);
      file_bytes.push_back(len[7:0]);
      repeat (len - 2) file_bytes.push_back(8'($urandom));
   endtask

   task automatic add_sof(input logic [7:0] marker, input logic [15:0] h,
                          input logic [15:0] w);
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(marker);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h11);
      file_bytes.push_back(8'h08);
      file_bytes.push_back(h[15:8]);
      file_bytes.push_back(h[7:0]);
      file_bytes.push_back(w[15:8]);
      file_bytes.push_back(w[7:0]);
      file_bytes.push_back(8'h03);
   endtask

   task automatic add_trail(input int unsigned n);
      repeat (n) file_bytes.push_back(8'($urandom));
   endtask

   task automatic add_soi();
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(ihsp_pkg::JPEG_SOI);
   endtask

   task automatic test_png_headers();
      add_png(32'hFFFF_FFFF, 32'd1);
      send_file();
      add_png(32'd1, 32'hFFFF_FFFF);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hA5);
      send_file();
      add_png(32'd640, 32'd0);
      send_file();
      add_png(32'd100, 32'd200);
      file_bytes[3] = 8'h46;
      send_file();
      add_png(32'd100, 32'd200);
      file_bytes[14] = 8'h00;
      send_file();
      add_png(32'd100, 32'd200);
      void'(file_bytes.pop_back());
      send_file();
   endtask

   task automatic test_jpeg_marker_walk();
      // fill, standalone markers, length segments, then a full-range frame
      add_soi();
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h7F);
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(ihsp_pkg::MARKER_RST0);
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(ihsp_pkg::MARKER_TEM);
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(ihsp_pkg::MARKER_EOI);
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      add_segment(8'hE0, 16);
      add_segment(ihsp_pkg::MARKER_DHT, 4);
      add_segment(ihsp_pkg::MARKER_JPG, 2);
      add_segment(ihsp_pkg::MARKER_DAC, 3);
      add_sof(ihsp_pkg::MARKER_SOF0, 16'hFFFF, 16'hFFFF);
      send_file();
      add_soi();
      add_sof(ihsp_pkg::MARKER_SOF15, 16'd1, 16'd1);
      send_file();
      add_soi();
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(8'hE1);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h01);
      add_sof(ihsp_pkg::MARKER_SOF0, 16'd5, 16'd5);
      send_file();
      add_soi();
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(8'hE2);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h00);
      send_file();
      add_soi();
      add_sof(8'hC2, 16'd480, 16'd640);
      void'(file_bytes.pop_back());
      void'(file_bytes.pop_back());
      send_file();
      add_soi();
      add_sof(8'hC1, 16'd0, 16'd300);
      send_file();
   endtask

   task automatic test_other_formats();
      file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hC0);
      file_bytes.push_back(8'h11);
      send_file();
      send_byte(ihsp_pkg::PNG_FIRST_BYTE, 1'b1);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'h01);
      file_bytes.push_back(8'h02);
      send_file();
   endtask

   task automatic test_output_backpressure();
      pop_hold_request = 400;
      repeat (30) send_byte(8'($urandom), 1'b1);
      add_png($urandom, $urandom_range(1, 65535));
      send_file();
   endtask

   task automatic test_random_files();
      int unsigned files_sent;
      int unsigned bytes_sent;
      int unsigned n;
      logic [31:0] w;
      logic [31:0] h;
      files_sent = 0;
      bytes_sent = 0;
      while (bytes_sent < 120 || files_sent < 8) begin
         send_gaps_on = !(files_sent >= 2 && files_sent < 6);
         pop_gaps_on  = send_gaps_on;
         n = $urandom_range(99);
         if (n < 35) begin
            w = ($urandom_range(3) == 0) ? $urandom_range(1, 4096) : $urandom;
            h = ($urandom_range(3) == 0) ? $urandom_range(1, 4096) : $urandom;
            if ($urandom_range(19) == 0) w = 32'd0;
            add_png(w, h);
            if ($urandom_range(9) == 0)
               file_bytes[$urandom_range(1, 15)] ^= 8'(1 << $urandom_range(7));
            if ($urandom_range(9) == 0)
               repeat ($urandom_range(1, 10)) void'(file_bytes.pop_back());
            add_trail($urandom_range(3));
         end else if (n < 80) begin
            file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
            file_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom)
                                                          : ihsp_pkg::JPEG_SOI);
            repeat ($urandom_range(4)) begin
               case ($urandom_range(7))
                  1: begin
                     file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
                     case ($urandom_range(2))
                        0: file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
                        1: file_bytes.push_back(ihsp_pkg::MARKER_TEM);
                        default: file_bytes.push_back(
                           8'($urandom_range(ihsp_pkg::MARKER_RST0, ihsp_pkg::MARKER_EOI)));
                     endcase
                  end
                  2, 3: add_segment(8'($urandom_range(8'hE0, 8'hFE)), $urandom_range(2, 8));
                  4: add_segment(ihsp_pkg::MARKER_DHT, $urandom_range(2, 6));
                  5: begin
                     file_bytes.push_back(ihsp_pkg::MARKER_PREFIX);
                     file_bytes.push_back(8'hE3);
                     file_bytes.push_back(8'h00);
                     file_bytes.push_back(8'($urandom_range(1)));
                  end
                  default: file_bytes.push_back(8'($urandom_range(254)));
               endcase
            end
            w = $urandom_range(1, 65535);
            h = $urandom_range(1, 65535);
            if ($urandom_range(19) == 0) h = 32'd0;
            add_sof(8'($urandom_range(ihsp_pkg::MARKER_SOF0, ihsp_pkg::MARKER_SOF15)),
                    h[15:0], w[15:0]);
            if ($urandom_range(9) == 0)
               repeat ($urandom_range(1, 5)) void'(file_bytes.pop_back());
            add_trail($urandom_range(3));
         end else begin
            add_trail($urandom_range(1, 8));
         end
         bytes_sent += file_bytes.size();
         files_sent++;
         send_file();
      end
      send_gaps_on = 1'b1;
      pop_gaps_on  = 1'b1;
   endtask

   initial begin : pop_driver
      int unsigned hold_left;
      hold_left = 0;
      rsp_pop   = 1'b0;
      forever begin
         @(negedge clock);
         if (pop_hold_request != 0) begin
            hold_left        = pop_hold_request;
            pop_hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_gaps_on && $urandom_range(99) < 13) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : size_checker
      image_size_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_sizes.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual w=%0d h=%0d found=%0b",
                     $time, rsp_image_width, rsp_image_height, rsp_size_found);
            errors++;
         end else begin
            want = expected_sizes.pop_front();
            if (rsp_image_width !== want.width) begin
               $display("%0t: image_width mismatch: expected %0d, actual %0d",
                        $time, want.width, rsp_image_width);
               errors++;
            end
            if (rsp_image_height !== want.height) begin
               $display("%0t: image_height mismatch: expected %0d, actual %0d",
                        $time, want.height, rsp_image_height);
               errors++;
            end
            if (rsp_size_found !== want.found) begin
               $display("%0t: size_found mismatch: expected %0b, actual %0b",
                        $time, want.found, rsp_size_found);
               errors++;
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout, %0d results outstanding", $time, expected_sizes.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_push      = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      clear_parse_state();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_png_headers();
      test_jpeg_marker_walk();
      test_other_formats();
      test_output_backpressure();
      test_random_files();

      // drop the request line and let the last results drain
      req_push <= 1'b0;
      while (expected_sizes.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
